### design/dlts_pkg.sv
// dlts_pkg: shared types and constants of the delta-list task scheduler
// entry layout, opcodes, controller command and datapath status structs
// no dependencies
`timescale 1ns / 1ps

package dlts_pkg;

    localparam int unsigned TICK_W     = 29;
    localparam int unsigned TAG_W      = 32;
    localparam int unsigned ID_W       = 4;
    localparam int unsigned MS_W       = 32;
    localparam int unsigned RESULT_MAX = 16;
    localparam int unsigned N_W        = 5;
    // ceil(2^35 / 10): x / 10 == (x * RECIP_TEN) >> 35 for every 32-bit x
    localparam logic [31:0] RECIP_TEN  = 32'hCCCC_CCCD;

    typedef enum logic [1:0] {
        OP_ADD      = 2'd0,
        OP_TICK     = 2'd1,
        OP_DISPATCH = 2'd2,
        OP_NONE     = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        OK_ADD,
        OK_REFUSE,
        OK_DISPATCH,
        OK_EMPTY
    } out_kind_t;

    typedef struct packed {
        logic [TICK_W-1:0] delta;
        logic [TICK_W-1:0] period;
        logic [TAG_W-1:0]  tag;
        logic [ID_W-1:0]   id;
    } entry_t;

    typedef struct packed {
        logic      add_load;
        logic      walk_rd;
        logic      walk_step;
        logic      shup_init;
        logic      shdn_init;
        logic      rd_idx;
        logic      rd_head;
        logic      wr_up;
        logic      wr_dn;
        logic      wr_new;
        logic      tick_wr;
        logic      len_dec;
        logic      head_load;
        logic      nid_inc;
        logic      n_clr;
        logic      out_load;
        out_kind_t out_kind;
        logic      out_last;
    } dp_cmd_t;

    typedef struct packed {
        logic len_zero;
        logic len_full;
        logic nid_full;
        logic walk_more;
        logic walk_pass;
        logic shup_more;
        logic shdn_more;
        logic head_due;
        logic per_zero;
        logic n_zero;
        logic n_lim;
        logic out_free;
    } dp_status_t;

    function automatic logic [TICK_W-1:0] div10(input logic [MS_W-1:0] x);
        logic [63:0] prod;
        prod = {32'd0, x} * {32'd0, RECIP_TEN};
        return prod[63:35];
    endfunction

endpackage

### design/dlts_if.sv
// dlts_if: request and response channel interfaces of the task scheduler
// depends on dlts_pkg for field widths
`timescale 1ns / 1ps

interface dlts_req_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                opcode;
    logic [dlts_pkg::MS_W-1:0] delay_ms;
    logic [dlts_pkg::MS_W-1:0] period_ms;
    logic [dlts_pkg::TAG_W-1:0] task_tag;

    modport source (output valid, opcode, delay_ms, period_ms, task_tag, input ready);
    modport sink (input valid, opcode, delay_ms, period_ms, task_tag, output ready);
endinterface

interface dlts_rsp_if;
    logic                       valid;
    logic                       ready;
    logic                       accepted;
    logic [dlts_pkg::ID_W-1:0]  task_id;
    logic                       due;
    logic [dlts_pkg::TAG_W-1:0] due_tag;
    logic                       last;

    modport source (output valid, accepted, task_id, due, due_tag, last, input ready);
    modport sink (input valid, accepted, task_id, due, due_tag, last, output ready);
endinterface

### design/dlts_dp.sv
// dlts_dp: datapath of the task scheduler: entry memory, walk and shift
// pointers, queue counters and the response register; depends on dlts_pkg
`timescale 1ns / 1ps

module dlts_dp #(
    parameter int unsigned MAX_TASKS = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  dlts_pkg::dp_cmd_t           cmd,
    output dlts_pkg::dp_status_t        status,
    input  logic [dlts_pkg::MS_W-1:0]   delay_ms,
    input  logic [dlts_pkg::MS_W-1:0]   period_ms,
    input  logic [dlts_pkg::TAG_W-1:0]  task_tag,
    input  logic                        out_ready,
    output logic                        out_valid,
    output logic                        accepted,
    output logic [dlts_pkg::ID_W-1:0]   task_id,
    output logic                        due,
    output logic [dlts_pkg::TAG_W-1:0]  due_tag,
    output logic                        last
);

    localparam int unsigned AW = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int unsigned PW = $clog2(MAX_TASKS + 1);
    localparam int unsigned IW = PW + 1;

    dlts_pkg::entry_t mem [MAX_TASKS];
    dlts_pkg::entry_t rd_reg;

    logic [PW-1:0]               len_reg, nid_reg, pos_reg;
    logic [IW-1:0]               idx_reg;
    logic [dlts_pkg::N_W-1:0]    n_reg;
    logic [dlts_pkg::TICK_W-1:0] rem_reg, per_reg;
    logic [dlts_pkg::TAG_W-1:0]  tag_reg;
    logic [dlts_pkg::ID_W-1:0]   id_reg;
    logic                        out_valid_reg;

    logic [IW-1:0]      idx_up, idx_dn, pos_ext;
    logic               mem_rd, mem_we;
    logic [AW-1:0]      rd_addr, wr_addr;
    dlts_pkg::entry_t   wr_data, moved;

    assign idx_up  = idx_reg + IW'(1);
    assign idx_dn  = idx_reg - IW'(1);
    assign pos_ext = IW'(pos_reg);

    assign status.len_zero  = (len_reg == '0);
    assign status.len_full  = (len_reg == PW'(MAX_TASKS));
    assign status.nid_full  = (nid_reg == PW'(MAX_TASKS));
    assign status.walk_more = (pos_reg < len_reg);
    assign status.walk_pass = (rd_reg.delta <= rem_reg);
    assign status.shup_more = (idx_up > pos_ext);
    assign status.shdn_more = (idx_reg < IW'(len_reg));
    assign status.head_due  = (rd_reg.delta == '0);
    assign status.per_zero  = (per_reg == '0);
    assign status.n_zero    = (n_reg == '0);
    assign status.n_lim     = (n_reg == dlts_pkg::N_W'(dlts_pkg::RESULT_MAX));
    assign status.out_free  = !out_valid_reg || out_ready;

    // the entry that lands right behind the new one gives up the new delta
    always_comb
    begin
        moved = rd_reg;
        if (cmd.wr_up && idx_reg == pos_ext)
        begin
            moved.delta = rd_reg.delta - rem_reg;
        end
        if (cmd.tick_wr)
        begin
            moved.delta = rd_reg.delta - dlts_pkg::TICK_W'(1);
        end
    end

    always_comb
    begin
        mem_rd  = cmd.walk_rd || cmd.rd_idx || cmd.rd_head;
        rd_addr = '0;
        if (cmd.walk_rd)
        begin
            rd_addr = pos_reg[AW-1:0];
        end
        else if (cmd.rd_idx)
        begin
            rd_addr = idx_reg[AW-1:0];
        end
        mem_we  = cmd.wr_up || cmd.wr_dn || cmd.wr_new || cmd.tick_wr;
        wr_addr = '0;
        wr_data = moved;
        if (cmd.wr_up)
        begin
            wr_addr = idx_up[AW-1:0];
        end
        else if (cmd.wr_dn)
        begin
            wr_addr = idx_dn[AW-1:0];
        end
        else if (cmd.wr_new)
        begin
            wr_addr = pos_reg[AW-1:0];
            wr_data = '{delta: rem_reg, period: per_reg, tag: tag_reg, id: id_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_rd)
        begin
            rd_reg <= mem[rd_addr];
        end
        if (mem_we)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.add_load)
        begin
            rem_reg <= dlts_pkg::div10(delay_ms);
            per_reg <= dlts_pkg::div10(period_ms);
            tag_reg <= task_tag;
            id_reg  <= dlts_pkg::ID_W'(nid_reg);
            pos_reg <= '0;
        end
        else if (cmd.head_load)
        begin
            rem_reg <= rd_reg.period;
            per_reg <= rd_reg.period;
            tag_reg <= rd_reg.tag;
            id_reg  <= rd_reg.id;
            pos_reg <= '0;
        end
        else if (cmd.walk_step)
        begin
            rem_reg <= rem_reg - rd_reg.delta;
            pos_reg <= pos_reg + PW'(1);
        end
        if (cmd.shup_init)
        begin
            idx_reg <= IW'(len_reg) - IW'(1);
        end
        else if (cmd.shdn_init)
        begin
            idx_reg <= IW'(1);
        end
        else if (cmd.wr_up)
        begin
            idx_reg <= idx_dn;
        end
        else if (cmd.wr_dn)
        begin
            idx_reg <= idx_up;
        end
        if (cmd.out_load)
        begin
            accepted <= 1'b0;
            task_id  <= '0;
            due      <= 1'b0;
            due_tag  <= '0;
            last     <= 1'b0;
            case (cmd.out_kind)
                dlts_pkg::OK_ADD:
                begin
                    accepted <= 1'b1;
                    task_id  <= id_reg;
                end
                dlts_pkg::OK_DISPATCH:
                begin
                    task_id <= id_reg;
                    due     <= 1'b1;
                    due_tag <= tag_reg;
                    last    <= cmd.out_last;
                end
                dlts_pkg::OK_EMPTY:
                begin
                    last <= 1'b1;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg       <= '0;
            nid_reg       <= '0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.wr_new)
            begin
                len_reg <= len_reg + PW'(1);
            end
            else if (cmd.len_dec)
            begin
                len_reg <= len_reg - PW'(1);
            end
            if (cmd.nid_inc)
            begin
                nid_reg <= nid_reg + PW'(1);
            end
            if (cmd.n_clr)
            begin
                n_reg <= '0;
            end
            else if (cmd.head_load)
            begin
                n_reg <= n_reg + dlts_pkg::N_W'(1);
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### design/dlts_ctrl.sv
// dlts_ctrl: sequencer of the task scheduler: add, tick and dispatch flows
// over the datapath's memory; depends on dlts_pkg
`timescale 1ns / 1ps

module dlts_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [1:0]            opcode,
    output logic                  in_ready,
    output dlts_pkg::dp_cmd_t     cmd,
    input  dlts_pkg::dp_status_t  status
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_REFUSE,
        S_WALK,
        S_WALK_CHK,
        S_SHUP_INIT,
        S_SHUP,
        S_SHUP_WR,
        S_NEW,
        S_ADD_OUT,
        S_TICK_RD,
        S_TICK_WR,
        S_DSP_RD,
        S_DSP_CHK,
        S_DSP_EMIT,
        S_DSP_TAKE,
        S_POP_INIT,
        S_POP,
        S_POP_WR,
        S_DSP_END
    } state_t;

    state_t state_reg, state_next;
    logic   from_add_reg, from_add_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd           = '0;
        cmd.out_kind  = dlts_pkg::OK_EMPTY;
        state_next    = state_reg;
        from_add_next = from_add_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (dlts_pkg::opcode_t'(opcode))
                        dlts_pkg::OP_ADD:
                        begin
                            cmd.add_load  = 1'b1;
                            from_add_next = 1'b1;
                            if (status.nid_full || status.len_full)
                            begin
                                state_next = S_REFUSE;
                            end
                            else
                            begin
                                state_next = S_WALK;
                            end
                        end
                        dlts_pkg::OP_TICK:
                        begin
                            state_next = S_TICK_RD;
                        end
                        dlts_pkg::OP_DISPATCH:
                        begin
                            cmd.n_clr  = 1'b1;
                            state_next = S_DSP_RD;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_REFUSE:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = dlts_pkg::OK_REFUSE;
                    state_next   = S_IDLE;
                end
            end
            S_WALK:
            begin
                if (status.walk_more)
                begin
                    cmd.walk_rd = 1'b1;
                    state_next  = S_WALK_CHK;
                end
                else
                begin
                    state_next = S_SHUP_INIT;
                end
            end
            S_WALK_CHK:
            begin
                if (status.walk_pass)
                begin
                    cmd.walk_step = 1'b1;
                    state_next    = S_WALK;
                end
                else
                begin
                    state_next = S_SHUP_INIT;
                end
            end
            S_SHUP_INIT:
            begin
                cmd.shup_init = 1'b1;
                state_next    = S_SHUP;
            end
            S_SHUP:
            begin
                if (status.shup_more)
                begin
                    cmd.rd_idx = 1'b1;
                    state_next = S_SHUP_WR;
                end
                else
                begin
                    state_next = S_NEW;
                end
            end
            S_SHUP_WR:
            begin
                cmd.wr_up  = 1'b1;
                state_next = S_SHUP;
            end
            S_NEW:
            begin
                cmd.wr_new = 1'b1;
                state_next = from_add_reg ? S_ADD_OUT : S_DSP_RD;
            end
            S_ADD_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = dlts_pkg::OK_ADD;
                    cmd.nid_inc  = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            S_TICK_RD:
            begin
                cmd.rd_head = 1'b1;
                state_next  = S_TICK_WR;
            end
            S_TICK_WR:
            begin
                cmd.tick_wr = !status.len_zero && !status.head_due;
                state_next  = S_IDLE;
            end
            S_DSP_RD:
            begin
                if (!status.len_zero && !status.n_lim)
                begin
                    cmd.rd_head = 1'b1;
                    state_next  = S_DSP_CHK;
                end
                else
                begin
                    state_next = S_DSP_END;
                end
            end
            S_DSP_CHK:
            begin
                state_next = status.head_due ? S_DSP_EMIT : S_DSP_END;
            end
            S_DSP_EMIT:
            begin
                // the previous due entry goes out once another one follows
                if (status.n_zero)
                begin
                    state_next = S_DSP_TAKE;
                end
                else if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = dlts_pkg::OK_DISPATCH;
                    state_next   = S_DSP_TAKE;
                end
            end
            S_DSP_TAKE:
            begin
                cmd.head_load = 1'b1;
                from_add_next = 1'b0;
                state_next    = S_POP_INIT;
            end
            S_POP_INIT:
            begin
                cmd.shdn_init = 1'b1;
                state_next    = S_POP;
            end
            S_POP:
            begin
                if (status.shdn_more)
                begin
                    cmd.rd_idx = 1'b1;
                    state_next = S_POP_WR;
                end
                else
                begin
                    cmd.len_dec = 1'b1;
                    state_next  = status.per_zero ? S_DSP_RD : S_WALK;
                end
            end
            S_POP_WR:
            begin
                cmd.wr_dn  = 1'b1;
                state_next = S_POP;
            end
            S_DSP_END:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = status.n_zero ? dlts_pkg::OK_EMPTY
                                                 : dlts_pkg::OK_DISPATCH;
                    cmd.out_last = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            from_add_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            from_add_reg <= from_add_next;
        end
    end

endmodule

### design/delta_list_task_scheduler.sv
// delta_list_task_scheduler: sorted delta-list timer queue of periodic tasks
// one request at a time; add walks the queue, then shifts entries up by one
// memory access pair each before it writes the new entry
// tick decrements the head delta; dispatch costs a pop per due task plus a reinsert of each periodic one
// a response waits in an output register; requests resume once it is loaded
// rst_n clears the queue length, identifier counter and controller; no memory sweep
`timescale 1ns / 1ps

module delta_list_task_scheduler #(
    parameter int unsigned MAX_TASKS = 16
) (
    input  logic       clk,
    input  logic       rst_n,
    dlts_req_if.sink   req,
    dlts_rsp_if.source rsp
);

    dlts_pkg::dp_cmd_t    cmd;
    dlts_pkg::dp_status_t status;

    dlts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .opcode   (req.opcode),
        .in_ready (req.ready),
        .cmd      (cmd),
        .status   (status)
    );

    dlts_dp #(
        .MAX_TASKS (MAX_TASKS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .delay_ms  (req.delay_ms),
        .period_ms (req.period_ms),
        .task_tag  (req.task_tag),
        .out_ready (rsp.ready),
        .out_valid (rsp.valid),
        .accepted  (rsp.accepted),
        .task_id   (rsp.task_id),
        .due       (rsp.due),
        .due_tag   (rsp.due_tag),
        .last      (rsp.last)
    );

endmodule

### design/dlts_checker.sv
// dlts_checker: port-level checks of the task scheduler, bound to the top
// depends on dlts_pkg and the channel interfaces
`timescale 1ns / 1ps

module dlts_checker (
    input logic        clk,
    input logic        rst_n,
    dlts_req_if.sink   req,
    dlts_rsp_if.source rsp
);

    // a response that is not taken stays valid and keeps its due tag
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && !rsp.ready |=> rsp.valid && $stable(rsp.due_tag))
        else $error("response dropped or changed while stalled");

    // work in progress blocks further requests
    assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready && req.opcode != dlts_pkg::OP_NONE |=> !req.ready)
        else $error("request taken while busy");

    // a tick never produces a response
    assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready && req.opcode == dlts_pkg::OP_TICK |=> !$rose(rsp.valid))
        else $error("tick produced a response");

    // a dispatch run is not interrupted by new requests
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.due && !rsp.last |-> !req.ready)
        else $error("request taken in the middle of a dispatch run");

endmodule

bind delta_list_task_scheduler dlts_checker u_dlts_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .rsp   (rsp)
);

### sim/dlts_checker.sv
// tb_dlts_checker: watches the request and response channels of the task scheduler,
// predicts every response from its own copy of the timer queue and compares them
// depends on dlts_pkg and the channel interfaces in dlts_if
`timescale 1ns / 1ps

module tb_dlts_checker #(
    parameter int unsigned MAX_TASKS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    dlts_req_if         req,
    dlts_rsp_if         rsp,
    output int unsigned fail_count,
    output int unsigned pending,
    output int unsigned rsp_count,
    output int unsigned due_count
);

    typedef struct packed {
        logic                       accepted;
        logic [dlts_pkg::ID_W-1:0]  task_id;
        logic                       due;
        logic [dlts_pkg::TAG_W-1:0] due_tag;
        logic                       last;
    } sched_rsp_t;

    logic [dlts_pkg::TICK_W-1:0] q_delta  [MAX_TASKS];
    logic [dlts_pkg::TICK_W-1:0] q_period [MAX_TASKS];
    logic [dlts_pkg::TAG_W-1:0]  q_tag    [MAX_TASKS];
    logic [dlts_pkg::ID_W-1:0]   q_id     [MAX_TASKS];
    int unsigned                 q_len;
    int unsigned                 id_next;

    sched_rsp_t rsp_fifo[$];

    // sorted insert, equal deadlines stay behind older entries
    task automatic queue_insert(input logic [dlts_pkg::TICK_W-1:0] ticks,
                                input logic [dlts_pkg::TICK_W-1:0] per,
                                input logic [dlts_pkg::TAG_W-1:0] tag,
                                input logic [dlts_pkg::ID_W-1:0] id);
        int unsigned                 pos;
        logic [dlts_pkg::TICK_W-1:0] rem;
        pos = 0;
        rem = ticks;
        if (q_len >= MAX_TASKS)
            return;
        while (pos < q_len && q_delta[pos] <= rem)
        begin
            rem = rem - q_delta[pos];
            pos++;
        end
        for (int i = q_len; i > pos; i--)
        begin
            q_delta[i]  = q_delta[i-1];
            q_period[i] = q_period[i-1];
            q_tag[i]    = q_tag[i-1];
            q_id[i]     = q_id[i-1];
        end
        q_delta[pos]  = rem;
        q_period[pos] = per;
        q_tag[pos]    = tag;
        q_id[pos]     = id;
        q_len++;
        if (pos + 1 < q_len)
            q_delta[pos+1] = q_delta[pos+1] - rem;
    endtask

    task automatic queue_pop();
        for (int i = 0; i + 1 < q_len; i++)
        begin
            q_delta[i]  = q_delta[i+1];
            q_period[i] = q_period[i+1];
            q_tag[i]    = q_tag[i+1];
            q_id[i]     = q_id[i+1];
        end
        q_len--;
    endtask

    task automatic predict_schedule(input dlts_pkg::opcode_t op,
                                    input logic [dlts_pkg::MS_W-1:0] dly,
                                    input logic [dlts_pkg::MS_W-1:0] per,
                                    input logic [dlts_pkg::TAG_W-1:0] tag);
        sched_rsp_t                  r;
        int unsigned                 n;
        logic [dlts_pkg::TICK_W-1:0] p;
        logic [dlts_pkg::TAG_W-1:0]  t;
        logic [dlts_pkg::ID_W-1:0]   id;
        r = '0;
        n = 0;
        case (op)
            dlts_pkg::OP_ADD:
            begin
                if (id_next < MAX_TASKS && q_len < MAX_TASKS)
                begin
                    queue_insert(dlts_pkg::TICK_W'(dly / 10), dlts_pkg::TICK_W'(per / 10),
                                 tag, dlts_pkg::ID_W'(id_next));
                    r.accepted = 1'b1;
                    r.task_id  = dlts_pkg::ID_W'(id_next);
                    id_next++;
                end
                rsp_fifo.push_back(r);
            end
            dlts_pkg::OP_TICK:
            begin
                if (q_len > 0 && q_delta[0] > 0)
                    q_delta[0] = q_delta[0] - 1'b1;
            end
            dlts_pkg::OP_DISPATCH:
            begin
                while (n < dlts_pkg::RESULT_MAX && q_len > 0 && q_delta[0] == '0)
                begin
                    p  = q_period[0];
                    t  = q_tag[0];
                    id = q_id[0];
                    r = '0;
                    r.task_id = id;
                    r.due     = 1'b1;
                    r.due_tag = t;
                    rsp_fifo.push_back(r);
                    n++;
                    queue_pop();
                    if (p != '0)
                        queue_insert(p, p, t, id);
                end
                if (n == 0)
                begin
                    r = '0;
                    r.last = 1'b1;
                    rsp_fifo.push_back(r);
                end
                else
                    rsp_fifo[rsp_fifo.size()-1].last = 1'b1;
            end
            default: ;
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        sched_rsp_t got;
        sched_rsp_t want;
        if (!rst_n)
        begin
            q_len      = 0;
            id_next    = 0;
            fail_count = 0;
            rsp_count  = 0;
            due_count  = 0;
            rsp_fifo.delete();
        end
        else
        begin
            if (req.valid && req.ready)
                predict_schedule(dlts_pkg::opcode_t'(req.opcode), req.delay_ms,
                                 req.period_ms, req.task_tag);
            if (rsp.valid && rsp.ready)
            begin
                got = '{rsp.accepted, rsp.task_id, rsp.due, rsp.due_tag, rsp.last};
                rsp_count++;
                if (rsp.due)
                    due_count++;
                if (rsp_fifo.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: response with nothing expected: %p", $realtime, got);
                end
                else
                begin
                    want = rsp_fifo.pop_front();
                    if (got !== want)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: mismatch expected %p actual %p", $realtime, want, got);
                    end
                end
            end
        end
        pending = rsp_fifo.size();
    end
endmodule

### sim/tb_delta_list_task_scheduler.sv
// tb_delta_list_task_scheduler: stimulus and verdict for the task scheduler
// depends on dlts_pkg, dlts_if, the block and sim/dlts_checker
`timescale 1ns / 1ps

module tb_delta_list_task_scheduler;

    localparam int unsigned CYCLE_LIMIT = 2000000;

    logic        clk;
    logic        rst_n;
    logic        quiet;
    int unsigned fail_count, pending, rsp_count, due_count;
    int unsigned cycles;
    int unsigned items_sent;

    dlts_req_if req ();
    dlts_rsp_if rsp ();

    delta_list_task_scheduler #(.MAX_TASKS(16)) dut (
        .clk(clk), .rst_n(rst_n), .req(req.sink), .rsp(rsp.source)
    );

    tb_dlts_checker #(.MAX_TASKS(16)) u_checker (
        .clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp),
        .fail_count(fail_count), .pending(pending),
        .rsp_count(rsp_count), .due_count(due_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > CYCLE_LIMIT)
            begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // receiver stalls in bursts unless in the quiet tail
    initial
    begin
        int unsigned burst;
        rsp.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (!quiet && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 10);
                rsp.ready = 1'b0;
                repeat (burst) @(negedge clk);
            end
            rsp.ready = 1'b1;
        end
    end

    task automatic send_item(input dlts_pkg::opcode_t op,
                             input logic [dlts_pkg::MS_W-1:0] dly,
                             input logic [dlts_pkg::MS_W-1:0] per,
                             input logic [dlts_pkg::TAG_W-1:0] tag);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            req.valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        req.valid     = 1'b1;
        req.opcode    = op;
        req.delay_ms  = dly;
        req.period_ms = per;
        req.task_tag  = tag;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        req.valid = 1'b0;
        while (pending != 0)
            @(negedge clk);
        // a tick gives no response and may still be running
        repeat (80) @(negedge clk);
    endtask

    initial
    begin
        int unsigned r;
        logic [dlts_pkg::MS_W-1:0] dly, per;
        quiet         = 1'b0;
        items_sent    = 0;
        req.valid     = 1'b0;
        req.opcode    = dlts_pkg::OP_NONE;
        req.delay_ms  = '0;
        req.period_ms = '0;
        req.task_tag  = '0;
        rst_n = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // empty queue, field extremes, due at once, one shot and periodic
        send_item(dlts_pkg::OP_DISPATCH, '0, '0, '0);
        send_item(dlts_pkg::OP_TICK, '0, '0, '0);
        send_item(dlts_pkg::OP_ADD, 32'd0, 32'd0, 32'hFFFF_FFFF);
        send_item(dlts_pkg::OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
        send_item(dlts_pkg::OP_ADD, 32'd25, 32'd20, 32'hA5A5_5A5A);
        send_item(dlts_pkg::OP_ADD, 32'd5, 32'd15, 32'h1234_5678);
        send_item(dlts_pkg::OP_ADD, 32'd0, 32'd9, 32'h8000_0001);
        send_item(dlts_pkg::OP_DISPATCH, '0, '0, '0);
        send_item(dlts_pkg::OP_TICK, '0, '0, '0);
        send_item(dlts_pkg::OP_DISPATCH, '0, '0, '0);
        send_item(dlts_pkg::OP_TICK, '0, '0, '0);
        send_item(dlts_pkg::OP_TICK, '0, '0, '0);
        send_item(dlts_pkg::OP_DISPATCH, '0, '0, '0);
        send_item(dlts_pkg::OP_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(dlts_pkg::OP_DISPATCH, '0, '0, '0);

        for (int i = 0; i < 160; i++)
        begin
            if (i == 80)
                wait_drained();
            if (i == 130)
                quiet = 1'b1;
            r = $urandom_range(0, 99);
            if (r < 15)
            begin
                dly = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 400) : $urandom;
                r = $urandom_range(0, 99);
                if (r < 40)
                    per = '0;
                else if (r < 85)
                    per = $urandom_range(10, 300);
                else if (r < 95)
                    per = $urandom_range(0, 9);
                else
                    per = $urandom;
                send_item(dlts_pkg::OP_ADD, dly, per, $urandom);
            end
            else if (r < 70)
                send_item(dlts_pkg::OP_TICK, $urandom, $urandom, $urandom);
            else if (r < 97)
                send_item(dlts_pkg::OP_DISPATCH, $urandom, $urandom, $urandom);
            else
                send_item(dlts_pkg::OP_NONE, $urandom, $urandom, $urandom);
        end

        wait_drained();
        $display("sent %0d requests, checked %0d responses, %0d of them due tasks",
                 items_sent, rsp_count, due_count);
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
